@@ rtl/core/kptt_pkg.sv @@
// ----------------------------------------------------------------------------
// kptt_pkg
// Shared types and constants of the keyed priority task table.
// ----------------------------------------------------------------------------
package kptt_pkg;

	localparam int KPTT_CAPACITY = 64;

	localparam int UID_W = 16;
	localparam int TID_W = 16;
	localparam int PRI_W = 30;

	typedef enum logic [1:0] {
		FUNC_ADD     = 2'd0,
		FUNC_CHANGE  = 2'd1,
		FUNC_REMOVE  = 2'd2,
		FUNC_EXECUTE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_FINISH
	} state_t;

	// one table slot as stored in the memory
	typedef struct packed {
		logic             vld;
		logic [UID_W-1:0] uid;
		logic [TID_W-1:0] tid;
		logic [PRI_W-1:0] pri;
	} entry_t;

endpackage

@@ rtl/core/kptt_ram.sv @@
// ----------------------------------------------------------------------------
// kptt_ram
// Generic single-port RAM, one write and one read of the same address per cycle, registered read.
// ----------------------------------------------------------------------------
module kptt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ rtl/core/keyed_priority_task_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_priority_task_table_unit
// Bounded table of tasks (user id, task id, priority) with add, change,
// remove and execute-top operations, one result per operation.
// ----------------------------------------------------------------------------
// Each operation makes one pass over the single-port table memory, one
// slot read per cycle, followed by a write state and a result state. The
// input side takes one operation at a time; a result waiting in the output
// register does not hold off the next input transfer. After reset the block
// clears the table (in_ready low) before the first transfer. Execute returns
// the valid entry of highest priority, ties going to the higher task id, and
// frees its slot. Adding a task id that is already present overwrites that
// entry; a new task goes to the lowest free slot. Status: ok, table full,
// task id not found, table empty.
// ----------------------------------------------------------------------------
module keyed_priority_task_table_unit
	import kptt_pkg::*;
#(
	parameter int CAPACITY = KPTT_CAPACITY
) (
	input  logic             clk,
	input  logic             arst_n,
	// input channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       func,
	input  logic [UID_W-1:0] user_id,
	input  logic [TID_W-1:0] task_id,
	input  logic [PRI_W-1:0] priority_req,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic             found,
	output logic [UID_W-1:0] user_id_out
);

	localparam int AW = $clog2(CAPACITY);   // slot index
	localparam int CW = $clog2(CAPACITY + 1); // pass counter, holds CAPACITY
	localparam int EW = $bits(entry_t);

	state_t state_q, state_d;

	// table memory port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	entry_t        ram_wdata;
	logic [EW-1:0] ram_rdata;
	entry_t        row;

	// pass counter: clear index after reset, read index during a scan
	logic [CW-1:0] rd_cnt_q;
	// slot read last cycle, its data is on ram_rdata now
	logic          chk_vld_s1;
	logic [AW-1:0] chk_idx_s1;

	// captured operation
	func_t            op_q;
	logic [UID_W-1:0] uid_q;
	logic [TID_W-1:0] tid_q;
	logic [PRI_W-1:0] pri_q;

	// scan results
	logic             match_hit_q;
	logic [AW-1:0]    match_idx_q;
	logic [UID_W-1:0] match_uid_q;
	logic             free_hit_q;
	logic [AW-1:0]    free_idx_q;
	logic             best_hit_q;
	logic [AW-1:0]    best_idx_q;
	logic [UID_W-1:0] best_uid_q;
	logic [TID_W-1:0] best_tid_q;
	logic [PRI_W-1:0] best_pri_q;

	// commit decision
	logic             wr_en;
	logic [AW-1:0]    wr_idx;
	entry_t           wr_data;
	status_t          res_status;
	logic             res_found;
	logic [UID_W-1:0] res_uid;

	logic             load_out;
	logic             take_row;

	// output register
	logic             out_valid_q;
	status_t          status_q;
	logic             found_q;
	logic [UID_W-1:0] uid_out_q;

	kptt_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign row = entry_t'(ram_rdata);

	// shared compare unit: one slot per cycle against the running best
	assign take_row = row.vld &&
		(!best_hit_q || (row.pri > best_pri_q) ||
		 ((row.pri == best_pri_q) && (row.tid > best_tid_q)));

	// what the operation commits once the scan is done
	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = match_idx_q;
		wr_data    = '{vld: 1'b1, uid: uid_q, tid: tid_q, pri: pri_q};
		res_status = STAT_OK;
		res_found  = 1'b0;
		res_uid    = '0;
		case (op_q)
			FUNC_ADD: begin
				if (match_hit_q) begin
					wr_en = 1'b1;
				end else if (free_hit_q) begin
					wr_en  = 1'b1;
					wr_idx = free_idx_q;
				end else begin
					res_status = STAT_FULL;
				end
			end
			FUNC_CHANGE: begin
				wr_data.uid = match_uid_q;
				if (match_hit_q) begin
					wr_en = 1'b1;
				end else begin
					res_status = STAT_NOT_FOUND;
				end
			end
			FUNC_REMOVE: begin
				wr_data.vld = 1'b0;
				if (match_hit_q) begin
					wr_en = 1'b1;
				end else begin
					res_status = STAT_NOT_FOUND;
				end
			end
			FUNC_EXECUTE: begin
				wr_data.vld = 1'b0;
				wr_idx      = best_idx_q;
				if (best_hit_q) begin
					wr_en     = 1'b1;
					res_found = 1'b1;
					res_uid   = best_uid_q;
				end else begin
					res_status = STAT_EMPTY;
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and memory control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = rd_cnt_q[AW-1:0];
		ram_wdata = '0;
		in_ready  = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				// zero row marks the slot free
				ram_we = 1'b1;
				if (rd_cnt_q == CW'(CAPACITY - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// done once every slot was read and the last row checked
				if ((rd_cnt_q == CW'(CAPACITY)) && !chk_vld_s1) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				ram_we    = wr_en;
				ram_addr  = wr_idx;
				ram_wdata = wr_data;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// pass counter and scan tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			chk_vld_s1  <= 1'b0;
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
			best_hit_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (rd_cnt_q == CW'(CAPACITY - 1)) begin
						rd_cnt_q <= '0;
					end else begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						rd_cnt_q    <= '0;
						chk_vld_s1  <= 1'b0;
						match_hit_q <= 1'b0;
						free_hit_q  <= 1'b0;
						best_hit_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_cnt_q != CW'(CAPACITY)) begin
						rd_cnt_q   <= rd_cnt_q + CW'(1);
						chk_vld_s1 <= 1'b1;
					end else begin
						chk_vld_s1 <= 1'b0;
					end
					if (chk_vld_s1) begin
						// first valid slot holding the task id
						if (row.vld && (row.tid == tid_q) && !match_hit_q) begin
							match_hit_q <= 1'b1;
						end
						// lowest free slot
						if (!row.vld && !free_hit_q) begin
							free_hit_q <= 1'b1;
						end
						if (take_row) begin
							best_hit_q <= 1'b1;
						end
					end
				end
				default: begin
					chk_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// operation fields and scan payload
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			op_q  <= func_t'(func);
			uid_q <= user_id;
			tid_q <= task_id;
			pri_q <= priority_req;
		end
		if ((state_q == S_SCAN) && (rd_cnt_q != CW'(CAPACITY))) begin
			chk_idx_s1 <= rd_cnt_q[AW-1:0];
		end
		if ((state_q == S_SCAN) && chk_vld_s1) begin
			if (row.vld && (row.tid == tid_q) && !match_hit_q) begin
				match_idx_q <= chk_idx_s1;
				match_uid_q <= row.uid;
			end
			if (!row.vld && !free_hit_q) begin
				free_idx_q <= chk_idx_s1;
			end
			if (take_row) begin
				best_idx_q <= chk_idx_s1;
				best_uid_q <= row.uid;
				best_tid_q <= row.tid;
				best_pri_q <= row.pri;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q  <= res_status;
			found_q   <= res_found;
			uid_out_q <= res_uid;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign user_id_out = uid_out_q;

endmodule

@@ rtl/core/kptt_checker.sv @@
// ----------------------------------------------------------------------------
// kptt_checker
// Port-level assertions for the keyed priority task table, bound to the top.
// ----------------------------------------------------------------------------
module kptt_checker
	import kptt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       status,
	input logic             found,
	input logic [UID_W-1:0] user_id_out
);

	// a returned task always carries ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (status == STAT_OK))
		else $error("found result with non-ok status");

	// no task returned means a zero owner
	a_zero_uid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (user_id_out == '0))
		else $error("nonzero user id without a found task");

	// one operation at a time: input closes after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after a transfer");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(status) && $stable(found) && $stable(user_id_out)))
		else $error("stalled result changed");

endmodule

bind keyed_priority_task_table_unit kptt_checker u_kptt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.found       (found),
	.user_id_out (user_id_out)
);
